FILE: hdl/segstk_pkg.sv
// ----------------------------------------------------------------------------
// Segmented stack package
// Shared word formats, request and status codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package segstk_pkg;

  // Default sizes for the top level parameters.
  localparam int NUM_SEGMENTS_DEF  = 16;
  localparam int SEGMENT_DEPTH_DEF = 16;
  localparam int DATA_WIDTH_DEF    = 32;

  // Capacity register width and its value after reset.
  localparam int          CAP_W     = 5;
  localparam logic [4:0]  CAP_RESET = 5'd16;

  // Request kinds carried in req_type.
  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_POP_AT = 2'd2,
    REQ_NONE   = 2'd3
  } req_kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_FULL      = 2'd3
  } status_code_t;

  // One request word.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] push_value;
    logic [3:0]  segment_index;
  } req_word_t;

  // One result word.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] top_value;
    logic [8:0]  total_count;
    logic [4:0]  active_segments;
    logic        is_empty;
  } rsp_word_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_EXEC,
    S_TOP_SEL,
    S_TOP_FILL,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         load_req;
    logic         look;
    logic         status_load;
    status_code_t status_code;
    logic         push_in;
    logic         open_seg;
    logic         pop;
    logic         top_sel;
    logic         top_fill;
    logic         load_out;
  } segstk_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    req_kind_t req_kind;
    logic      list_empty;
    logic      idx_bad;
    logic      seg_full;
    logic      no_room;
  } segstk_stat_t;

endpackage

FILE: hdl/segmented_stack_with_indexed_pop_core.sv
// ----------------------------------------------------------------------------
// Segmented stack with indexed pop
// A stack kept as an ordered list of fixed-capacity segments, with push, pop
// from the last segment and pop from a chosen segment, one result per request.
// ----------------------------------------------------------------------------
// Sequence: lookup, update, then top-of-stack readback before the result is loaded;
// a pop error or an unused request kind skips the update, and an empty stack skips
// the element memory read. The readback goes through the segment list and fill
// memory, then the element memory. No new request is taken until the last result is loaded.
// Reset: synchronous; clears the counters and sets capacity to 16. Memories are
// not cleared and there is no clearing pass.
module segmented_stack_with_indexed_pop_core #(
  parameter int NUM_SEGMENTS  = segstk_pkg::NUM_SEGMENTS_DEF,
  parameter int SEGMENT_DEPTH = segstk_pkg::SEGMENT_DEPTH_DEF,
  parameter int DATA_WIDTH    = segstk_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [segstk_pkg::CAP_W-1:0]  cfg_data,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  segstk_pkg::req_word_t         req_word,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output segstk_pkg::rsp_word_t         rsp_word
);
  import segstk_pkg::*;

  segstk_cmd_t  cmd;
  segstk_stat_t stat;

  // Capacity writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  // Sequencer.
  segstk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Storage and arithmetic.
  segstk_datapath #(
    .NUM_SEGMENTS  (NUM_SEGMENTS),
    .SEGMENT_DEPTH (SEGMENT_DEPTH),
    .DATA_WIDTH    (DATA_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .req_word  (req_word),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_word  (rsp_word)
  );

endmodule

FILE: hdl/segstk_ctrl.sv
// ----------------------------------------------------------------------------
// Segmented stack controller
// Sequences each request through lookup, update and top-of-stack readback,
// and owns the request and result handshakes.
// ----------------------------------------------------------------------------
module segstk_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_ready,
  output logic                    rsp_valid,
  input  logic                    rsp_ready,
  input  segstk_pkg::segstk_stat_t stat,
  output segstk_pkg::segstk_cmd_t  cmd
);
  import segstk_pkg::*;

  state_t state;
  state_t state_next;
  logic   pop_req;
  logic   slot_free;

  assign pop_req   = (stat.req_kind == REQ_POP) || (stat.req_kind == REQ_POP_AT);
  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  // State register and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_LOOK;
      end
      S_LOOK: begin
        if (stat.req_kind == REQ_PUSH) begin
          state_next = S_EXEC;
        end else if (pop_req && !stat.list_empty &&
                     !(stat.req_kind == REQ_POP_AT && stat.idx_bad)) begin
          state_next = S_EXEC;
        end else begin
          state_next = S_TOP_SEL;
        end
      end
      S_EXEC: begin
        state_next = S_TOP_SEL;
      end
      S_TOP_SEL: begin
        state_next = stat.list_empty ? S_DONE : S_TOP_FILL;
      end
      S_TOP_FILL: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Commands.
  always_comb begin
    cmd = '0;
    cmd.status_code = ST_OK;
    case (state)
      S_IDLE: begin
        cmd.load_req = req_valid;
      end
      S_LOOK: begin
        cmd.look        = 1'b1;
        cmd.status_load = 1'b1;
        if (pop_req && stat.list_empty) begin
          cmd.status_code = ST_EMPTY;
        end else if (stat.req_kind == REQ_POP_AT && stat.idx_bad) begin
          cmd.status_code = ST_BAD_INDEX;
        end
      end
      S_EXEC: begin
        if (stat.req_kind == REQ_PUSH) begin
          if (!stat.list_empty && !stat.seg_full) begin
            cmd.push_in = 1'b1;
          end else if (stat.no_room) begin
            cmd.status_load = 1'b1;
            cmd.status_code = ST_FULL;
          end else begin
            cmd.open_seg = 1'b1;
          end
        end else if (pop_req) begin
          cmd.pop = 1'b1;
        end
      end
      S_TOP_SEL: begin
        cmd.top_sel = 1'b1;
      end
      S_TOP_FILL: begin
        cmd.top_fill = 1'b1;
      end
      S_DONE: begin
        cmd.load_out = slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // An accepted request always starts with the lookup step.
  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_LOOK))
    else $error("accepted request did not enter lookup");

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!rsp_valid || rsp_ready))
    else $error("result register overwritten");

  // The update step only follows the lookup step.
  a_exec_after_look: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> ($past(state) == S_LOOK))
    else $error("update step without lookup");

endmodule

FILE: hdl/segstk_datapath.sv
// ----------------------------------------------------------------------------
// Segmented stack datapath
// Holds the element memory, the per-segment fill memory, the ordered segment
// list, the free segment stack, the counters and the result register.
// ----------------------------------------------------------------------------
module segstk_datapath #(
  parameter int NUM_SEGMENTS  = segstk_pkg::NUM_SEGMENTS_DEF,
  parameter int SEGMENT_DEPTH = segstk_pkg::SEGMENT_DEPTH_DEF,
  parameter int DATA_WIDTH    = segstk_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [segstk_pkg::CAP_W-1:0]  cfg_data,
  input  segstk_pkg::req_word_t         req_word,
  input  segstk_pkg::segstk_cmd_t       cmd,
  output segstk_pkg::segstk_stat_t      stat,
  output segstk_pkg::rsp_word_t         rsp_word
);
  import segstk_pkg::*;

  localparam int PW    = $clog2(NUM_SEGMENTS);
  localparam int CNW   = $clog2(NUM_SEGMENTS + 1);
  localparam int FW    = $clog2(SEGMENT_DEPTH + 1);
  localparam int WORDS = NUM_SEGMENTS * SEGMENT_DEPTH;
  localparam int AW    = $clog2(WORDS);
  localparam int ECW   = $clog2(WORDS + 1);
  localparam int CW    = (FW > CAP_W) ? FW : CAP_W;
  localparam int IXW   = (CNW > 4) ? CNW : 4;
  localparam int XW    = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
  localparam int TW    = (ECW > 9) ? ECW : 9;
  localparam int SW    = (CNW > 5) ? CNW : 5;

  localparam logic [CNW-1:0] ONE_C   = CNW'(1);
  localparam logic [CNW-1:0] SEG_MAX = CNW'(NUM_SEGMENTS);
  localparam logic [FW-1:0]  ONE_F   = FW'(1);
  localparam logic [ECW-1:0] ONE_E   = ECW'(1);
  localparam logic [AW-1:0]  DEPTH_A = AW'(SEGMENT_DEPTH);
  localparam logic [CW-1:0]  DEPTH_C = CW'(SEGMENT_DEPTH);

  // Control state.
  logic [CAP_W-1:0] cap;
  logic [CNW-1:0]   count;
  logic [ECW-1:0]   elems;
  logic [CNW-1:0]   sp;
  logic [CNW-1:0]   fresh;

  // Request and working registers.
  req_word_t        req_q;
  logic [PW-1:0]    order [NUM_SEGMENTS];
  logic [PW-1:0]    pos;
  logic [PW-1:0]    p;
  status_code_t     status_q;
  logic             top_zero;

  // Memories and their read registers.
  logic [DATA_WIDTH-1:0] store_mem [WORDS];
  logic [DATA_WIDTH-1:0] store_q;
  logic [FW-1:0]         fill_mem [NUM_SEGMENTS];
  logic [FW-1:0]         fill_q;
  logic [PW-1:0]         free_mem [NUM_SEGMENTS];
  logic [PW-1:0]         free_q;

  // Combinational helpers.
  req_kind_t             kind;
  logic [PW-1:0]         last_pos;
  logic [PW-1:0]         look_pos;
  logic [PW-1:0]         ord_rd_idx;
  logic [PW-1:0]         ord_rd;
  logic [CW-1:0]         eff_cap;
  logic                  last_elem;
  logic [PW-1:0]         p_new;
  logic [PW-1:0]         wr_seg;
  logic [FW-1:0]         wr_off;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic [XW-1:0]         push_ext;
  logic [XW-1:0]         top_ext;
  logic [TW-1:0]         elems_ext;
  logic [SW-1:0]         count_ext;
  logic                  drop;

  assign kind       = req_kind_t'(req_q.req_type);
  assign last_pos   = PW'(count - ONE_C);
  assign look_pos   = (kind == REQ_POP_AT) ? PW'(req_q.segment_index) : last_pos;
  assign ord_rd_idx = cmd.look ? look_pos : last_pos;
  assign ord_rd     = order[ord_rd_idx];
  assign last_elem  = (fill_q == ONE_F);
  assign drop       = cmd.pop && last_elem;
  assign p_new      = (sp != '0) ? free_q : PW'(fresh);

  // Effective capacity: zero acts as one, large values clamp to the depth.
  always_comb begin
    eff_cap = CW'(cap);
    if (cap == '0) begin
      eff_cap = CW'(1);
    end else if (CW'(cap) > DEPTH_C) begin
      eff_cap = DEPTH_C;
    end
  end

  // Status toward the controller.
  assign stat.req_kind   = kind;
  assign stat.list_empty = (count == '0);
  assign stat.idx_bad    = (IXW'(req_q.segment_index) >= IXW'(count));
  assign stat.seg_full   = (CW'(fill_q) >= eff_cap);
  assign stat.no_room    = (count >= SEG_MAX);

  // Element memory addresses: a push writes the next free slot of its segment,
  // the readback reads the top slot of the last segment.
  assign wr_seg   = cmd.open_seg ? p_new : p;
  assign wr_off   = cmd.open_seg ? '0 : fill_q;
  assign wr_addr  = AW'(AW'(wr_seg) * DEPTH_A) + AW'(wr_off);
  assign rd_addr  = AW'(AW'(p) * DEPTH_A) + AW'(fill_q - ONE_F);
  assign push_ext = XW'(req_q.push_value);
  assign top_ext  = XW'(store_q);
  assign elems_ext = TW'(elems);
  assign count_ext = SW'(count);

  // Element memory.
  always_ff @(posedge clk) begin
    if (cmd.push_in || cmd.open_seg) begin
      store_mem[wr_addr] <= push_ext[DATA_WIDTH-1:0];
    end
    if (cmd.top_fill) begin
      store_q <= store_mem[rd_addr];
    end
  end

  // Fill memory: a new segment starts at one, pushes write the raised fill, pops the reduced fill.
  always_ff @(posedge clk) begin
    if (cmd.open_seg) begin
      fill_mem[p_new] <= ONE_F;
    end else if (cmd.push_in) begin
      fill_mem[p] <= fill_q + ONE_F;
    end else if (cmd.pop && !last_elem) begin
      fill_mem[p] <= fill_q - ONE_F;
    end
    if (cmd.look || cmd.top_sel) begin
      fill_q <= fill_mem[ord_rd];
    end
  end

  // Free segment stack: dropped segments are pushed, openings pop the top.
  always_ff @(posedge clk) begin
    if (drop) begin
      free_mem[PW'(sp)] <= p;
    end
    if (cmd.look) begin
      free_q <= free_mem[PW'(sp - ONE_C)];
    end
  end

  // Segment list: append on opening, close the gap when a segment empties.
  always_ff @(posedge clk) begin
    if (cmd.open_seg) begin
      order[PW'(count)] <= p_new;
    end
    if (drop) begin
      for (int i = 0; i < NUM_SEGMENTS - 1; i++) begin
        if ((CNW'(i) >= CNW'(pos)) && (CNW'(i + 1) < count)) begin
          order[i] <= order[i + 1];
        end
      end
    end
  end

  // Request capture and working registers.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= req_word;
    end
    if (cmd.look) begin
      pos <= look_pos;
    end
    if (cmd.look || cmd.top_sel) begin
      p <= ord_rd;
    end
    if (cmd.status_load) begin
      status_q <= cmd.status_code;
    end
    if (cmd.top_sel) begin
      top_zero <= (count == '0);
    end
  end

  // Counters and capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap   <= CAP_RESET;
      count <= '0;
      elems <= '0;
      sp    <= '0;
      fresh <= '0;
    end else begin
      if (cfg_valid) begin
        cap <= cfg_data;
      end
      if (cmd.open_seg) begin
        count <= count + ONE_C;
        if (sp != '0) begin
          sp <= sp - ONE_C;
        end else begin
          fresh <= fresh + ONE_C;
        end
      end else if (drop) begin
        count <= count - ONE_C;
        sp    <= sp + ONE_C;
      end
      if (cmd.open_seg || cmd.push_in) begin
        elems <= elems + ONE_E;
      end else if (cmd.pop) begin
        elems <= elems - ONE_E;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_word.status          <= status_q;
      rsp_word.top_value       <= top_zero ? 32'd0 : top_ext[31:0];
      rsp_word.total_count     <= elems_ext[8:0];
      rsp_word.active_segments <= count_ext[4:0];
      rsp_word.is_empty        <= (elems == '0);
    end
  end

  // The list never holds more segments than exist.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= SEG_MAX)
    else $error("segment count above the number of segments");

  // The stack holds no elements exactly when the list holds no segments.
  a_empty_match: assert property (@(posedge clk) disable iff (rst)
    (elems == '0) == (count == '0))
    else $error("element count and segment count disagree");

  // Every segment handed out is either listed or on the free stack.
  a_free_account: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, sp} + {1'b0, count}) == {1'b0, fresh})
    else $error("free segment accounting broken");

endmodule
